// ----- sv/tllp_pkg.sv -----
package tllp_pkg;

   localparam logic [15:0] CH_NUL    = 16'h0000;
   localparam logic [15:0] CH_LF     = 16'h000A;
   localparam logic [15:0] CH_CR     = 16'h000D;
   localparam logic [15:0] CH_SPACE  = 16'h0020;
   localparam logic [15:0] CH_AMP    = 16'h0026;
   localparam logic [15:0] CH_QUOTE  = 16'h0027;
   localparam logic [15:0] CH_COMMA  = 16'h002C;
   localparam logic [15:0] CH_MINUS  = 16'h002D;
   localparam logic [15:0] CH_ZERO   = 16'h0030;
   localparam logic [15:0] CH_NINE   = 16'h0039;
   localparam logic [15:0] CH_LT     = 16'h003C;
   localparam logic [15:0] CH_GT     = 16'h003E;
   localparam logic [15:0] CH_UPPER_A = 16'h0041;
   localparam logic [15:0] CH_UPPER_Z = 16'h005A;
   localparam logic [15:0] CH_LBRACK = 16'h005B;
   localparam logic [15:0] CH_RBRACK = 16'h005D;
   localparam logic [15:0] CASE_FOLD = 16'h0020;

   localparam logic [1:0] KIND_TEXT = 2'd0;
   localparam logic [1:0] KIND_WORD = 2'd1;
   localparam logic [1:0] KIND_LINE = 2'd2;

   // Last position of the entity pattern "&apos;".
   localparam logic [2:0] ENTITY_LAST = 3'd5;

   typedef enum logic [3:0] {
      MODE_HDR        = 4'd0,
      MODE_HDR_BR     = 4'd1,
      MODE_LSTART     = 4'd2,
      MODE_LNUM_FRESH = 4'd3,
      MODE_LNUM_NEG   = 4'd4,
      MODE_LNUM_DIG   = 4'd5,
      MODE_LNUM_DEAD  = 4'd6,
      MODE_LNUM_SEP   = 4'd7,
      MODE_WNUM_FRESH = 4'd8,
      MODE_WNUM_NEG   = 4'd9,
      MODE_WNUM_DIG   = 4'd10,
      MODE_WNUM_DEAD  = 4'd11,
      MODE_WNUM_SEP   = 4'd12,
      MODE_TEXT       = 4'd13,
      MODE_EOL        = 4'd14,
      MODE_FLUSH      = 4'd15
   } mode_type;

   typedef enum logic [2:0] {
      SUB_FRESH,
      SUB_NEG,
      SUB_DIG,
      SUB_DEAD,
      SUB_SEP
   } sub_type;

   typedef struct packed {
      logic       is_digit;
      logic       is_minus;
      logic       is_space;
      logic       is_lbrack;
      logic       is_lt;
      logic       is_eol;
      logic       is_amp;
      logic       is_sep;
      logic       starts_line;
      logic [3:0] digit;
   } klass_type;

   typedef struct packed {
      logic [15:0] ch;
      logic        last;
      klass_type   klass;
   } item_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] char_value;
      logic [31:0] time_start;
      logic [31:0] time_length;
      logic [31:0] word_flag;
      logic [15:0] text_length;
      logic [31:0] gap;
      logic        has_gap;
   } result_type;

   typedef struct packed {
      logic step;
      logic emit;
      logic done;
   } back_ctrl_type;

   function automatic logic [15:0] entity_char(input logic [2:0] idx);
      logic [15:0] c;
      unique case (idx)
         3'd0:    c = 16'h0026;
         3'd1:    c = 16'h0061;
         3'd2:    c = 16'h0070;
         3'd3:    c = 16'h006F;
         3'd4:    c = 16'h0073;
         3'd5:    c = 16'h003B;
         default: c = 16'h0000;
      endcase
      return c;
   endfunction

   function automatic mode_type num_mode(input logic is_word, input sub_type s);
      mode_type m;
      unique case (s)
         SUB_FRESH: m = is_word ? MODE_WNUM_FRESH : MODE_LNUM_FRESH;
         SUB_NEG:   m = is_word ? MODE_WNUM_NEG : MODE_LNUM_NEG;
         SUB_DIG:   m = is_word ? MODE_WNUM_DIG : MODE_LNUM_DIG;
         SUB_DEAD:  m = is_word ? MODE_WNUM_DEAD : MODE_LNUM_DEAD;
         default:   m = is_word ? MODE_WNUM_SEP : MODE_LNUM_SEP;
      endcase
      return m;
   endfunction

endpackage

// ----- sv/timed_lyric_line_parser.sv -----
// Timed lyric line parser: one UTF-16 character per request on the req_
// channel (req_ch, req_last), results on the rsp_ channel, both valid/ready.
// A request yields zero to eight results: text characters, word records and
// line records; rsp_last_of_run marks the final result of each request.
// Requests enter a two-entry queue that classifies the character; the parser
// behind it takes one step per cycle while a request waits and the output
// has room, and emits at most one result per step. Most characters are
// consumed in the step that first sees them, so the sustained rate is one
// request per cycle while the output is not held. A character that ends a
// number field or a line takes extra steps: a line end inside text closes
// the word and then the line, and a letter that cuts a word header short
// closes every remaining field in turn. A broken entity is detected, then
// its held characters go out one per step, and a request with req_last set
// adds steps to flush a held entity and close the open word and line. Each
// result waits in a staging slot until the parser knows whether another
// result of the same request follows, then it is offered on rsp_valid from
// the output register. Reset empties the queue and output, returns to header
// skipping and clears all times and counts. When rsp_ready is low while a
// result is offered, the output register holds, the parser stops, and req_ready drops once the queue is full.
module timed_lyric_line_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_ch,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [15:0] rsp_char_value,
   output logic signed [31:0] rsp_time_start,
   output logic signed [31:0] rsp_time_length,
   output logic signed [31:0] rsp_word_flag,
   output logic [15:0] rsp_text_length,
   output logic signed [31:0] rsp_gap,
   output logic        rsp_has_gap,
   output logic        rsp_last_of_run
);

   logic                    head_valid;
   tllp_pkg::item_type      head;
   logic                    out_free;
   tllp_pkg::back_ctrl_type ctrl;
   tllp_pkg::result_type    res;
   tllp_pkg::result_type    rsp_data;

   tllp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_ch     (req_ch),
      .req_last   (req_last),
      .head_valid (head_valid),
      .head       (head),
      .pop        (ctrl.done)
   );

   tllp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .out_free   (out_free),
      .ctrl       (ctrl),
      .res        (res)
   );

   tllp_out u_out (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .res             (res),
      .out_free        (out_free),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .rsp_last_of_run (rsp_last_of_run)
   );

   assign rsp_kind = rsp_data.kind;
   assign rsp_char_value = rsp_data.char_value;
   assign rsp_time_start = rsp_data.time_start;
   assign rsp_time_length = rsp_data.time_length;
   assign rsp_word_flag = rsp_data.word_flag;
   assign rsp_text_length = rsp_data.text_length;
   assign rsp_gap = rsp_data.gap;
   assign rsp_has_gap = rsp_data.has_gap;

   a_reset_empties_output: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_accept_fills_queue: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> head_valid)
      else $error("accepted request missing from queue");

   a_pop_needs_step: assert property (@(posedge clock) disable iff (reset)
      (ctrl.done || ctrl.emit) |-> (ctrl.step && head_valid && out_free))
      else $error("parser advanced without a request or output space");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind == tllp_pkg::KIND_TEXT || rsp_kind == tllp_pkg::KIND_WORD
                     || rsp_kind == tllp_pkg::KIND_LINE))
      else $error("illegal result kind");

endmodule

// ----- sv/tllp_front.sv -----
module tllp_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [15:0]       req_ch,
   input  logic              req_last,
   output logic              head_valid,
   output tllp_pkg::item_type head,
   input  logic              pop
);

   tllp_pkg::item_type  queue_ff [2];
   tllp_pkg::item_type  item_in;
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [1:0]          count_ff, count_in;
   logic                push;

   always_comb begin
      item_in.ch = req_ch;
      item_in.last = req_last;
      item_in.klass.is_digit = (req_ch >= tllp_pkg::CH_ZERO) && (req_ch <= tllp_pkg::CH_NINE);
      item_in.klass.is_minus = (req_ch == tllp_pkg::CH_MINUS);
      item_in.klass.is_space = (req_ch == tllp_pkg::CH_SPACE);
      item_in.klass.is_lbrack = (req_ch == tllp_pkg::CH_LBRACK);
      item_in.klass.is_lt = (req_ch == tllp_pkg::CH_LT);
      item_in.klass.is_eol = (req_ch == tllp_pkg::CH_CR) || (req_ch == tllp_pkg::CH_LF)
                             || (req_ch == tllp_pkg::CH_NUL);
      item_in.klass.is_amp = (req_ch == tllp_pkg::CH_AMP);
      item_in.klass.is_sep = (req_ch == tllp_pkg::CH_COMMA) || (req_ch == tllp_pkg::CH_RBRACK)
                             || (req_ch == tllp_pkg::CH_GT);
      item_in.klass.starts_line = item_in.klass.is_space || item_in.klass.is_digit
                                  || item_in.klass.is_minus || item_in.klass.is_sep
                                  || item_in.klass.is_lt;
      item_in.klass.digit = req_ch[3:0];
   end

   assign req_ready = (count_ff != 2'd2);
   assign push = req_valid && req_ready;
   assign head_valid = (count_ff != 2'd0);
   assign head = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

// ----- sv/tllp_back.sv -----
module tllp_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    head_valid,
   input  tllp_pkg::item_type      head,
   input  logic                    out_free,
   output tllp_pkg::back_ctrl_type ctrl,
   output tllp_pkg::result_type    res
);

   tllp_pkg::mode_type mode_ff, mode_in;
   logic [31:0] accum_ff, accum_in;
   logic        neg_ff, neg_in;
   logic [1:0]  field_ff, field_in;
   logic [31:0] lstart_ff, lstart_in;
   logic [31:0] ldecl_ff, ldecl_in;
   logic [31:0] wsum_ff, wsum_in;
   logic [31:0] wstart_ff, wstart_in;
   logic [31:0] wdur_ff, wdur_in;
   logic [31:0] wflag_ff, wflag_in;
   logic [15:0] wcnt_ff, wcnt_in;
   logic [15:0] lcnt_ff, lcnt_in;
   logic [31:0] prev_end_ff, prev_end_in;
   logic        prev_valid_ff, prev_valid_in;
   logic [2:0]  match_ff, match_in;
   logic [2:0]  fidx_ff, fidx_in;
   logic        fin_ff, fin_in;
   logic [15:0] held_ff [5];
   logic [15:0] held_in [5];

   logic        step;
   logic        is_word;
   tllp_pkg::sub_type sub;
   logic [31:0] value;
   logic [31:0] accum_x10;
   logic [31:0] line_len;
   logic [15:0] folded;
   logic        commit_en, word_en, line_en, text_en;
   logic [15:0] text_ch;
   logic        consumed, finalize, begin_line, begin_word, clear_num;
   logic        emit, done;
   tllp_pkg::klass_type k;

   assign step = head_valid && out_free;
   assign k = head.klass;
   assign value = neg_ff ? (32'd0 - accum_ff) : accum_ff;
   assign accum_x10 = {accum_ff[28:0], 3'b000} + {accum_ff[30:0], 1'b0};
   assign line_len = ($signed(wsum_ff) < $signed(ldecl_ff)) ? wsum_ff : ldecl_ff;
   assign folded = ((head.ch >= tllp_pkg::CH_UPPER_A) && (head.ch <= tllp_pkg::CH_UPPER_Z))
                   ? (head.ch + tllp_pkg::CASE_FOLD) : head.ch;

   always_comb begin
      is_word = 1'b0;
      sub = tllp_pkg::SUB_SEP;
      unique case (mode_ff) inside
         tllp_pkg::MODE_LNUM_FRESH: sub = tllp_pkg::SUB_FRESH;
         tllp_pkg::MODE_LNUM_NEG:   sub = tllp_pkg::SUB_NEG;
         tllp_pkg::MODE_LNUM_DIG:   sub = tllp_pkg::SUB_DIG;
         tllp_pkg::MODE_LNUM_DEAD:  sub = tllp_pkg::SUB_DEAD;
         tllp_pkg::MODE_WNUM_FRESH: begin is_word = 1'b1; sub = tllp_pkg::SUB_FRESH; end
         tllp_pkg::MODE_WNUM_NEG:   begin is_word = 1'b1; sub = tllp_pkg::SUB_NEG; end
         tllp_pkg::MODE_WNUM_DIG:   begin is_word = 1'b1; sub = tllp_pkg::SUB_DIG; end
         tllp_pkg::MODE_WNUM_DEAD:  begin is_word = 1'b1; sub = tllp_pkg::SUB_DEAD; end
         tllp_pkg::MODE_WNUM_SEP:   is_word = 1'b1;
         default:                   is_word = 1'b0;
      endcase
   end

   always_comb begin
      mode_in = mode_ff;
      accum_in = accum_ff;
      neg_in = neg_ff;
      field_in = field_ff;
      lstart_in = lstart_ff;
      ldecl_in = ldecl_ff;
      wsum_in = wsum_ff;
      wstart_in = wstart_ff;
      wdur_in = wdur_ff;
      wflag_in = wflag_ff;
      wcnt_in = wcnt_ff;
      lcnt_in = lcnt_ff;
      prev_end_in = prev_end_ff;
      prev_valid_in = prev_valid_ff;
      match_in = match_ff;
      fidx_in = fidx_ff;
      fin_in = fin_ff;
      held_in = held_ff;
      commit_en = 1'b0;
      word_en = 1'b0;
      line_en = 1'b0;
      text_en = 1'b0;
      text_ch = head.ch;
      consumed = 1'b0;
      finalize = 1'b0;
      begin_line = 1'b0;
      begin_word = 1'b0;
      clear_num = 1'b0;
      res = '0;
      emit = 1'b0;
      done = 1'b0;

      if (mode_ff == tllp_pkg::MODE_FLUSH) begin
         // Held entity characters go out one per cycle while the parser steps; the breaking character waits.
         text_en = 1'b1;
         text_ch = held_ff[fidx_ff];
         if (fidx_ff + 3'd1 == match_ff) begin
            match_in = 3'd0;
            mode_in = tllp_pkg::MODE_TEXT;
         end else begin
            fidx_in = fidx_ff + 3'd1;
         end
      end else if (fin_ff) begin
         // End of text: close whatever is open, one result at a time, before the last request is popped.
         unique case (mode_ff) inside
            tllp_pkg::MODE_HDR, tllp_pkg::MODE_HDR_BR, tllp_pkg::MODE_LSTART:
               finalize = 1'b1;
            tllp_pkg::MODE_LNUM_SEP: begin
               line_en = 1'b1;
               mode_in = tllp_pkg::MODE_LSTART;
            end
            tllp_pkg::MODE_WNUM_SEP: begin
               word_en = 1'b1;
               mode_in = tllp_pkg::MODE_EOL;
            end
            tllp_pkg::MODE_TEXT: begin
               if (match_ff != 3'd0) begin
                  fidx_in = 3'd0;
                  mode_in = tllp_pkg::MODE_FLUSH;
               end else begin
                  word_en = 1'b1;
                  mode_in = tllp_pkg::MODE_EOL;
               end
            end
            tllp_pkg::MODE_EOL: begin
               line_en = 1'b1;
               mode_in = tllp_pkg::MODE_LSTART;
            end
            default: begin
               commit_en = 1'b1;
               mode_in = tllp_pkg::num_mode(is_word, tllp_pkg::SUB_SEP);
            end
         endcase
      end else begin
         unique case (mode_ff) inside
            tllp_pkg::MODE_HDR: begin
               consumed = 1'b1;
               if (k.is_lbrack) begin
                  mode_in = tllp_pkg::MODE_HDR_BR;
               end
            end
            tllp_pkg::MODE_HDR_BR: begin
               if (k.is_lbrack) begin
                  consumed = 1'b1;
               end else if (k.is_digit) begin
                  begin_line = 1'b1;
               end else begin
                  mode_in = tllp_pkg::MODE_HDR;
                  consumed = 1'b1;
               end
            end
            tllp_pkg::MODE_LSTART: begin
               if (k.is_lbrack) begin
                  begin_line = 1'b1;
                  consumed = 1'b1;
               end else if (k.starts_line) begin
                  begin_line = 1'b1;
               end else begin
                  consumed = 1'b1;
               end
            end
            tllp_pkg::MODE_TEXT: begin
               if (match_ff != 3'd0) begin
                  if (folded == tllp_pkg::entity_char(match_ff)) begin
                     consumed = 1'b1;
                     if (match_ff == tllp_pkg::ENTITY_LAST) begin
                        text_en = 1'b1;
                        text_ch = tllp_pkg::CH_QUOTE;
                        match_in = 3'd0;
                     end else begin
                        held_in[match_ff] = head.ch;
                        match_in = match_ff + 3'd1;
                     end
                  end else begin
                     fidx_in = 3'd0;
                     mode_in = tllp_pkg::MODE_FLUSH;
                  end
               end else if (k.is_lt) begin
                  word_en = 1'b1;
                  begin_word = 1'b1;
                  consumed = 1'b1;
               end else if (k.is_eol) begin
                  word_en = 1'b1;
                  mode_in = tllp_pkg::MODE_EOL;
               end else if (k.is_amp) begin
                  held_in[0] = head.ch;
                  match_in = 3'd1;
                  consumed = 1'b1;
               end else begin
                  text_en = 1'b1;
                  consumed = 1'b1;
               end
            end
            tllp_pkg::MODE_EOL: begin
               line_en = 1'b1;
               mode_in = tllp_pkg::MODE_LSTART;
            end
            default: begin
               if (sub != tllp_pkg::SUB_SEP) begin
                  if (k.is_digit && (sub != tllp_pkg::SUB_DEAD)) begin
                     accum_in = ((sub == tllp_pkg::SUB_DIG) ? accum_x10 : 32'd0)
                                + {28'd0, k.digit};
                     mode_in = tllp_pkg::num_mode(is_word, tllp_pkg::SUB_DIG);
                     consumed = 1'b1;
                  end else if (k.is_minus && (sub != tllp_pkg::SUB_DEAD)) begin
                     consumed = 1'b1;
                     if (sub == tllp_pkg::SUB_FRESH) begin
                        neg_in = 1'b1;
                        mode_in = tllp_pkg::num_mode(is_word, tllp_pkg::SUB_NEG);
                     end else begin
                        mode_in = tllp_pkg::num_mode(is_word, tllp_pkg::SUB_DEAD);
                     end
                  end else if ((sub == tllp_pkg::SUB_DEAD) && (k.is_digit || k.is_minus)) begin
                     consumed = 1'b1;
                  end else if ((sub == tllp_pkg::SUB_FRESH) && k.is_space) begin
                     consumed = 1'b1;
                  end else begin
                     commit_en = 1'b1;
                     mode_in = tllp_pkg::num_mode(is_word, tllp_pkg::SUB_SEP);
                  end
               end else if (k.is_sep) begin
                  consumed = 1'b1;
               end else if (!is_word) begin
                  if (field_ff == 2'd0) begin
                     field_in = 2'd1;
                     clear_num = 1'b1;
                     mode_in = tllp_pkg::MODE_LNUM_FRESH;
                  end else if (k.is_lt) begin
                     begin_word = 1'b1;
                     consumed = 1'b1;
                  end else begin
                     line_en = 1'b1;
                     mode_in = tllp_pkg::MODE_LSTART;
                  end
               end else begin
                  if (field_ff < 2'd2) begin
                     field_in = field_ff + 2'd1;
                     clear_num = 1'b1;
                     mode_in = tllp_pkg::MODE_WNUM_FRESH;
                  end else begin
                     wcnt_in = 16'd0;
                     mode_in = tllp_pkg::MODE_TEXT;
                  end
               end
            end
         endcase
      end

      if (begin_line) begin
         lstart_in = 32'd0;
         ldecl_in = 32'd0;
         wsum_in = 32'd0;
         lcnt_in = 16'd0;
         field_in = 2'd0;
         clear_num = 1'b1;
         mode_in = tllp_pkg::MODE_LNUM_FRESH;
      end
      if (begin_word) begin
         wstart_in = 32'd0;
         wdur_in = 32'd0;
         wflag_in = 32'd0;
         field_in = 2'd0;
         clear_num = 1'b1;
         mode_in = tllp_pkg::MODE_WNUM_FRESH;
      end

      if (commit_en) begin
         if (is_word) begin
            if (field_ff == 2'd0) begin
               wstart_in = value;
            end else if (field_ff == 2'd1) begin
               wdur_in = value;
               wsum_in = wsum_ff + value;
            end else begin
               wflag_in = value;
            end
         end else if (field_ff == 2'd0) begin
            lstart_in = value;
         end else begin
            ldecl_in = value;
         end
      end

      if (text_en) begin
         emit = 1'b1;
         res.kind = tllp_pkg::KIND_TEXT;
         res.char_value = text_ch;
         if (wcnt_ff != 16'hFFFF) begin
            wcnt_in = wcnt_ff + 16'd1;
         end
         if (lcnt_ff != 16'hFFFF) begin
            lcnt_in = lcnt_ff + 16'd1;
         end
      end
      if (word_en) begin
         emit = 1'b1;
         res.kind = tllp_pkg::KIND_WORD;
         res.time_start = wstart_ff;
         res.time_length = wdur_ff;
         res.word_flag = wflag_ff;
         res.text_length = wcnt_ff;
      end
      if (line_en) begin
         emit = 1'b1;
         res.kind = tllp_pkg::KIND_LINE;
         res.time_start = lstart_ff;
         res.time_length = line_len;
         res.text_length = lcnt_ff;
         res.gap = prev_valid_ff ? (lstart_ff - prev_end_ff) : 32'd0;
         res.has_gap = prev_valid_ff;
         prev_end_in = lstart_ff + line_len;
         prev_valid_in = 1'b1;
      end

      if (finalize) begin
         mode_in = tllp_pkg::MODE_HDR;
         prev_valid_in = 1'b0;
         prev_end_in = 32'd0;
         match_in = 3'd0;
         field_in = 2'd0;
         clear_num = 1'b1;
         fin_in = 1'b0;
         done = 1'b1;
      end else if (consumed) begin
         if (head.last) begin
            fin_in = 1'b1;
         end else begin
            done = 1'b1;
         end
      end

      if (clear_num) begin
         accum_in = 32'd0;
         neg_in = 1'b0;
      end
   end

   assign ctrl.step = step;
   assign ctrl.emit = step && emit;
   assign ctrl.done = step && done;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= tllp_pkg::MODE_HDR;
         accum_ff <= 32'd0;
         neg_ff <= 1'b0;
         field_ff <= 2'd0;
         lstart_ff <= 32'd0;
         ldecl_ff <= 32'd0;
         wsum_ff <= 32'd0;
         wstart_ff <= 32'd0;
         wdur_ff <= 32'd0;
         wflag_ff <= 32'd0;
         wcnt_ff <= 16'd0;
         lcnt_ff <= 16'd0;
         prev_end_ff <= 32'd0;
         prev_valid_ff <= 1'b0;
         match_ff <= 3'd0;
         fidx_ff <= 3'd0;
         fin_ff <= 1'b0;
      end else if (step) begin
         mode_ff <= mode_in;
         accum_ff <= accum_in;
         neg_ff <= neg_in;
         field_ff <= field_in;
         lstart_ff <= lstart_in;
         ldecl_ff <= ldecl_in;
         wsum_ff <= wsum_in;
         wstart_ff <= wstart_in;
         wdur_ff <= wdur_in;
         wflag_ff <= wflag_in;
         wcnt_ff <= wcnt_in;
         lcnt_ff <= lcnt_in;
         prev_end_ff <= prev_end_in;
         prev_valid_ff <= prev_valid_in;
         match_ff <= match_in;
         fidx_ff <= fidx_in;
         fin_ff <= fin_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         held_ff <= held_in;
      end
   end

endmodule

// ----- sv/tllp_out.sv -----
module tllp_out (
   input  logic                    clock,
   input  logic                    reset,
   input  tllp_pkg::back_ctrl_type ctrl,
   input  tllp_pkg::result_type    res,
   output logic                    out_free,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output tllp_pkg::result_type    rsp_data,
   output logic                    rsp_last_of_run
);

   // The staging slot holds the newest result until it is known whether
   // another one of the same request follows.
   logic                 pend_valid_ff, pend_valid_in;
   logic                 pend_final_ff, pend_final_in;
   tllp_pkg::result_type pend_ff, pend_in;
   logic                 out_valid_ff, out_valid_in;
   logic                 out_last_ff, out_last_in;
   tllp_pkg::result_type out_ff, out_in;
   logic                 push;

   assign out_free = !out_valid_ff || rsp_ready;
   assign push = out_free && pend_valid_ff
                 && (pend_final_ff || ctrl.emit || ctrl.done);

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_final_in = pend_final_ff;
      pend_in = pend_ff;
      out_valid_in = out_valid_ff;
      out_last_in = out_last_ff;
      out_in = out_ff;
      if (ctrl.emit) begin
         pend_valid_in = 1'b1;
         pend_final_in = ctrl.done;
         pend_in = res;
      end else if (push) begin
         pend_valid_in = 1'b0;
         pend_final_in = 1'b0;
      end
      if (push) begin
         out_valid_in = 1'b1;
         out_in = pend_ff;
         out_last_in = pend_final_ff || (ctrl.done && !ctrl.emit);
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         pend_final_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         pend_final_ff <= pend_final_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      out_ff <= out_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_ff;
   assign rsp_last_of_run = out_last_ff;

endmodule
